// File: hdl/fpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared codes and types for the fixed-partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int MODE_W   = 2;
  localparam int ACTIVE_W = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCKS = 1'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic              entry_occ;
    logic [MODE_W-1:0] mode;
  } fit_ctrl_t;

endpackage

// File: hdl/fpfa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_req_if / fpfa_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface fpfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [fpfa_pkg::FUNC_W-1:0]   func;
  logic [fpfa_pkg::INDEX_W-1:0]  block_index;
  logic [fpfa_pkg::VALUE_W-1:0]  size_value;

  modport source (output valid, func, block_index, size_value, input ready);
  modport sink   (input valid, func, block_index, size_value, output ready);
endinterface

interface fpfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [fpfa_pkg::INDEX_W-1:0]  granted_block;
  logic [fpfa_pkg::VALUE_W-1:0]  remaining_space;

  modport source (output valid, granted, granted_block, remaining_space, input ready);
  modport sink   (input valid, granted, granted_block, remaining_space, output ready);
endinterface

// File: hdl/fpfa_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_fit_unit
// Shared compare unit that judges one partition per step and keeps the pick.
// ----------------------------------------------------------------------------
module fpfa_fit_unit #(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  fpfa_pkg::fit_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]      entry_idx,
  input  logic [SIZE_BITS-1:0]  entry_size,
  input  logic [SIZE_BITS-1:0]  request,
  output logic                  found,
  output logic [IDX_W-1:0]      pick,
  output logic [SIZE_BITS-1:0]  remaining
);
  import fpfa_pkg::*;

  logic [SIZE_BITS-1:0] best_size;
  logic                 fits;
  logic                 take;

  always_comb begin
    fits = !ctrl.entry_occ && (entry_size >= request);
    take = 1'b0;
    if (fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (ctrl.mode == MODE_BEST) begin
        take = entry_size < best_size;
      end else if (ctrl.mode == MODE_WORST) begin
        take = entry_size > best_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.step && take) begin
      found     <= 1'b1;
      pick      <= entry_idx;
      best_size <= entry_size;
    end
  end

  assign remaining = best_size - request;

endmodule

// File: hdl/fixed_partition_fit_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top
// Fixed-partition allocator with first, best and worst fit policies.
// ----------------------------------------------------------------------------
// Load, release and unused items go straight to the report state for the result beat.
// An allocate scans min(active_blocks, NUM_BLOCKS) partitions, reading one partition
// per cycle into a single shared compare unit.
// One item is in work at a time; the next is taken the cycle after the result register
// loads.
// Synchronous reset clears the occupied marks; partition sizes are unknown until loaded.
module fixed_partition_fit_allocator_top #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  fpfa_req_if.sink                       req,
  fpfa_rsp_if.source                     rsp,
  input  logic                           cfg_wr_en,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpfa_pkg::CFG_W-1:0]     cfg_data
);
  import fpfa_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t                state;
  logic [MODE_W-1:0]     fit_mode;
  logic [ACTIVE_W-1:0]   active_blocks;
  logic [FUNC_W-1:0]     func_q;
  logic [SIZE_BITS-1:0]  request;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      cnt;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic [SIZE_BITS-1:0]  rd_size;
  logic                  rd_occ;
  logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] occ;
  logic                  accept;
  logic                  out_free;
  logic [CNT_W-1:0]      limit_next;
  fit_ctrl_t             ctrl;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [SIZE_BITS-1:0]  remaining;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  always_comb begin
    if (int'(active_blocks) > NUM_BLOCKS) begin
      limit_next = CNT_W'(NUM_BLOCKS);
    end else begin
      limit_next = CNT_W'(active_blocks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= MODE_FIRST;
      active_blocks <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIT_MODE:      fit_mode      <= cfg_data[MODE_W-1:0];
        REG_ACTIVE_BLOCKS: active_blocks <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (req.func == FUNC_ALLOC) ? S_SCAN : S_REPORT;
          end
        end
        S_SCAN: begin
          if (cnt < limit) begin
            rd_vld <= 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= req.func;
      request <= SIZE_BITS'(req.size_value);
      limit   <= limit_next;
      cnt     <= '0;
    end else if (state == S_SCAN && cnt < limit) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.func == FUNC_LOAD && int'(req.block_index) < NUM_BLOCKS) begin
      size_mem[IDX_W'(req.block_index)] <= SIZE_BITS'(req.size_value);
    end
    rd_size <= size_mem[cnt[IDX_W-1:0]];
    rd_occ  <= occ[cnt[IDX_W-1:0]];
    rd_idx  <= cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (accept && req.func == FUNC_RELEASE) begin
      occ <= '0;
    end else if (state == S_REPORT && out_free && func_q == FUNC_ALLOC && found) begin
      occ[pick] <= 1'b1;
    end
  end

  always_comb begin
    ctrl.clear     = accept;
    ctrl.step      = rd_vld;
    ctrl.entry_occ = rd_occ;
    ctrl.mode      = fit_mode;
  end

  fpfa_fit_unit #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .clk        (clk),
    .ctrl       (ctrl),
    .entry_idx  (rd_idx),
    .entry_size (rd_size),
    .request    (request),
    .found      (found),
    .pick       (pick),
    .remaining  (remaining)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_REPORT && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REPORT && out_free) begin
      if (func_q == FUNC_ALLOC && found) begin
        rsp.granted         <= 1'b1;
        rsp.granted_block   <= INDEX_W'(pick);
        rsp.remaining_space <= VALUE_W'(remaining);
      end else begin
        rsp.granted         <= 1'b0;
        rsp.granted_block   <= '0;
        rsp.remaining_space <= '0;
      end
    end
  end

endmodule

// File: hdl/fpfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_checker
// Port-level checks on the allocator's request and result channels.
// ----------------------------------------------------------------------------
module fpfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          granted,
  input logic [fpfa_pkg::INDEX_W-1:0]  granted_block,
  input logic [fpfa_pkg::VALUE_W-1:0]  remaining_space
);

  // A result that is not granted carries no block and no space.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !granted) |-> (granted_block == '0 && remaining_space == '0))
    else $error("refused result has nonzero fields");

  // Only one item is in work: a taken request closes the input side.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

  // A result beat never appears in the cycle right after a request beat.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("result too early");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(granted) && $stable(granted_block) && $stable(remaining_space)))
    else $error("stalled result changed");

endmodule

bind fixed_partition_fit_allocator_top fpfa_checker u_fpfa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .granted         (rsp.granted),
  .granted_block   (rsp.granted_block),
  .remaining_space (rsp.remaining_space)
);
